// ===== rtl/soc_pkg.sv =====
// -----------------------------------------------------------------------------
// soc_pkg
// Shared types and constants of the substring occurrence counter.
// -----------------------------------------------------------------------------
package soc_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PAT_REGS   = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_0   = 3'd0,
    CFG_PAT_1   = 3'd1,
    CFG_PAT_2   = 3'd2,
    CFG_PAT_3   = 3'd3,
    CFG_PAT_LEN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              chunk_start;
    logic              search_start;
  } text_req_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] match_count;
  } match_res_t;

  // Control handed from the top level down the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/soc_stream_if.sv =====
// -----------------------------------------------------------------------------
// soc_stream_if
// Valid/ready channel carrying one request payload.
// -----------------------------------------------------------------------------
interface soc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/soc_cfg.sv =====
// -----------------------------------------------------------------------------
// soc_cfg
// Pattern registers, plus a per-cell aligned copy of the pattern and its length.
// -----------------------------------------------------------------------------
module soc_cfg #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [soc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [soc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic [MAX_PATTERN-1:0][soc_pkg::BYTE_W-1:0] cell_pat_o,
  output logic [soc_pkg::LEN_W-1:0]             len_o
);

  logic [soc_pkg::PAT_REGS-1:0][soc_pkg::CFG_DATA_W-1:0] pat_q;
  logic [soc_pkg::LEN_W-1:0] len_reg_q;
  logic [soc_pkg::PAT_BYTES-1:0][soc_pkg::BYTE_W-1:0] pat_flat;
  logic [soc_pkg::LEN_W-1:0] len_c;
  logic [MAX_PATTERN-1:0][soc_pkg::BYTE_W-1:0] cell_pat_d, cell_pat_q;
  logic [soc_pkg::LEN_W-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      len_reg_q <= soc_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        soc_pkg::CFG_PAT_0:   pat_q[0] <= cfg_data_i;
        soc_pkg::CFG_PAT_1:   pat_q[1] <= cfg_data_i;
        soc_pkg::CFG_PAT_2:   pat_q[2] <= cfg_data_i;
        soc_pkg::CFG_PAT_3:   pat_q[3] <= cfg_data_i;
        soc_pkg::CFG_PAT_LEN: len_reg_q <= cfg_data_i[soc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_flat = pat_q;
  assign len_c = (len_reg_q > soc_pkg::LEN_W'(MAX_PATTERN)) ?
                 soc_pkg::LEN_W'(MAX_PATTERN) : len_reg_q;

  // Cell k (k-th newest byte) compares against pattern byte len-1-k
  always_comb begin
    logic [soc_pkg::LEN_W-1:0] pos;
    pos = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pos = len_c - soc_pkg::LEN_W'(1) - soc_pkg::LEN_W'(k);
      if (soc_pkg::LEN_W'(k) < len_c) begin
        cell_pat_d[k] = pat_flat[pos[soc_pkg::PAT_IDX_W-1:0]];
      end else begin
        cell_pat_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_pat_q <= '0;
      len_q      <= soc_pkg::LEN_W'(1);
    end else begin
      cell_pat_q <= cell_pat_d;
      len_q      <= len_c;
    end
  end

  assign cell_pat_o = cell_pat_q;
  assign len_o      = len_q;

endmodule

// ===== rtl/soc_cell.sv =====
// -----------------------------------------------------------------------------
// soc_cell
// One window cell: holds a byte and its valid bit, compares with its pattern byte.
// -----------------------------------------------------------------------------
module soc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  soc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [soc_pkg::BYTE_W-1:0]  byte_i,
  input  logic                        valid_i,
  input  logic [soc_pkg::BYTE_W-1:0]  pat_byte_i,
  input  logic                        in_use_i,
  output logic [soc_pkg::BYTE_W-1:0]  byte_o,
  output logic                        valid_o,
  output logic                        ok_o
);

  logic [soc_pkg::BYTE_W-1:0] byte_d, byte_q;
  logic                       valid_d, valid_q;

  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      byte_d  = ctrl_i.clear ? '0 : byte_i;
      valid_d = ctrl_i.clear ? 1'b0 : valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      byte_q  <= byte_d;
      valid_q <= valid_d;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  // Unused cells never veto a match
  assign ok_o    = !in_use_i || (valid_q && (byte_q == pat_byte_i));

endmodule

// ===== rtl/substring_occurrence_counter.sv =====
// -----------------------------------------------------------------------------
// substring_occurrence_counter
// Streaming exact-match counter over a text byte stream.
// -----------------------------------------------------------------------------
// Usage:
//   text_i carries one request per text byte (text_byte, chunk_start,
//   search_start); result_o returns one result per request (match_here,
//   match_count) in order. Both are valid/ready channels.
//   The pattern (up to MAX_PATTERN bytes) and its length are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no request is in flight; a write
//   takes effect for requests accepted from the next cycle on.
// Timing:
//   An accepted request passes from the window stage to the result register.
//   One request per cycle is sustained while result_o is ready: the window
//   row shifts on every accepted byte; compare and count update fit one stage.
// Reset:
//   Clears the window, the match count and both pipeline stages; pattern
//   bytes reset to zero and the length to one.
// Stall:
//   When result_o is not ready the result register holds; one more request
//   may sit in the window stage, after which text_i drops ready.
// -----------------------------------------------------------------------------
module substring_occurrence_counter #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  soc_stream_if.sink                     text_i,
  soc_stream_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [soc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [soc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [MAX_PATTERN-1:0][soc_pkg::BYTE_W-1:0] cell_pat;
  logic [soc_pkg::LEN_W-1:0]                   len;

  soc_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_pat_o (cell_pat),
    .len_o      (len)
  );

  // Handshake: window stage (A) feeds the result register (O)
  logic a_valid_d, a_valid_q;
  logic a_search_q;
  logic o_valid_d, o_valid_q;
  logic o_free, a_move, accept;

  assign o_free       = !o_valid_q || result_o.ready;
  assign a_move       = a_valid_q && o_free;
  assign text_i.ready = !a_valid_q || o_free;
  assign accept       = text_i.valid && text_i.ready;

  assign a_valid_d = accept || (a_valid_q && !a_move);
  assign o_valid_d = a_move || (o_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Search flag travels with the byte into the window stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_search_q <= text_i.data.search_start;
    end
  end

  // Window row: cell 0 takes the new byte, each cell hands its byte onward
  soc_pkg::cell_ctrl_t                          ctrl_head, ctrl_tail;
  logic [MAX_PATTERN-1:0][soc_pkg::BYTE_W-1:0] cell_byte;
  logic [MAX_PATTERN-1:0]                       cell_valid;
  logic [MAX_PATTERN-1:0]                       cell_ok;
  logic [MAX_PATTERN-1:0]                       cell_in_use;

  assign ctrl_head.shift = accept;
  assign ctrl_head.clear = 1'b0;
  assign ctrl_tail.shift = accept;
  // A new chunk or search drops everything older than this byte
  assign ctrl_tail.clear = text_i.data.chunk_start || text_i.data.search_start;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign cell_in_use[k] = soc_pkg::LEN_W'(k) < len;
    if (k == 0) begin : g_head
      soc_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl_head),
        .byte_i     (text_i.data.text_byte),
        .valid_i    (1'b1),
        .pat_byte_i (cell_pat[k]),
        .in_use_i   (cell_in_use[k]),
        .byte_o     (cell_byte[k]),
        .valid_o    (cell_valid[k]),
        .ok_o       (cell_ok[k])
      );
    end else begin : g_body
      soc_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl_tail),
        .byte_i     (cell_byte[k-1]),
        .valid_i    (cell_valid[k-1]),
        .pat_byte_i (cell_pat[k]),
        .in_use_i   (cell_in_use[k]),
        .byte_o     (cell_byte[k]),
        .valid_o    (cell_valid[k]),
        .ok_o       (cell_ok[k])
      );
    end
  end

  // Match and saturating count
  logic                        hit;
  logic [soc_pkg::COUNT_W-1:0] cnt_base, cnt_d, cnt_q;
  logic                        match_q;

  assign hit      = (&cell_ok) && (len != '0);
  assign cnt_base = a_search_q ? '0 : cnt_q;
  assign cnt_d    = (hit && (cnt_base != soc_pkg::COUNT_MAX)) ?
                    cnt_base + soc_pkg::COUNT_W'(1) : cnt_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (a_move) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      match_q <= hit;
    end
  end

  assign result_o.valid            = o_valid_q;
  assign result_o.data.match_here  = match_q;
  assign result_o.data.match_count = cnt_q;

endmodule
